[rtl/afcd_pkg.sv]
`default_nettype none

package afcd_pkg;

    // Frame layout
    localparam int FRAME_BYTES   = 11;
    localparam int IDX_W         = 4;
    localparam int NET_LAST_IDX  = 3;
    localparam int MSG_IDX       = 4;
    localparam int COMPL_IDX     = 5;
    localparam int CRC_IDX       = 6;
    localparam int DEV_FIRST_IDX = 7;

    // CRC-8, Dallas/Maxim reflected polynomial
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    // Register defaults and limits
    localparam logic [15:0] TIMEOUT_RESET     = 16'd2000;
    localparam logic [7:0]  MIN_REPEATS_RESET = 8'd10;
    localparam logic [7:0]  COUNT_MAX         = 8'hFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPEATS = 1'b1;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COMPL_ERR = 2'd1,
        ST_CRC_ERR   = 2'd2
    } status_t;

    // Bit positions in the per-frame failure flags
    localparam int FAIL_COMPL = 0;
    localparam int FAIL_CRC   = 1;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        start_of_frame;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [31:0] net_id;
        logic [31:0] dev_id;
        logic [7:0]  message;
        logic [1:0]  status;
        logic [7:0]  repeat_count;
        logic        publish;
    } out_t;

    // Checked frame handed from the byte assembler to the filter
    typedef struct packed {
        logic [31:0] net_id;
        logic [31:0] dev_id;
        logic [7:0]  message;
        status_t     status;
        logic [31:0] now_ms;
    } frame_rec_t;

    // One byte of the CRC-8, bit at a time
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/alarm_frame_check_and_dedup.sv]
// A frame's result is held in the frame record register, then in the result register.
// Bytes are taken at one per cycle while in_stall is low.
// The frame record register and the result register are separate, so bytes keep
// flowing while a result waits; in_stall rises only when both are held.
// Reset (rst_n, async, active low) clears byte count, CRC, filter state and
// registers to defaults; no clearing pass is needed.
`default_nettype none

module alarm_frame_check_and_dedup (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire afcd_pkg::in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output afcd_pkg::out_t                         out_data,
    input  wire logic                              cfg_we,
    input  wire logic [afcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [afcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import afcd_pkg::*;

    logic [15:0] timeout_reg;
    logic [7:0]  min_repeats_reg;

    logic [31:0] last_net_reg, last_net_next;
    logic [31:0] last_dev_reg, last_dev_next;
    logic [7:0]  last_msg_reg, last_msg_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [7:0]  dup_reg, dup_next;

    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    logic        rec_valid;
    logic        rec_take;
    frame_rec_t  rec;

    logic        advance;
    logic [31:0] gap;
    logic        same;
    logic [7:0]  dup_inc;

    // Byte assembly and frame checks
    afcd_frame u_frame (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .rec_valid(rec_valid),
        .rec_take (rec_take),
        .rec      (rec)
    );

    // Result register moves when empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign rec_take = advance && rec_valid;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            min_repeats_reg <= MIN_REPEATS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                CFG_MIN_REPEATS: min_repeats_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Repeat test and counter update
    always_comb
    begin
        gap     = rec.now_ms - last_time_reg;
        dup_inc = dup_reg + 8'd1;
        same    = (dup_reg != 8'd0) && (rec.net_id == last_net_reg) &&
                  (rec.dev_id == last_dev_reg) && (rec.message == last_msg_reg) &&
                  (gap <= {16'h0, timeout_reg});

        last_net_next  = last_net_reg;
        last_dev_next  = last_dev_reg;
        last_msg_next  = last_msg_reg;
        last_time_next = last_time_reg;
        dup_next       = dup_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_valid_next       = rec_valid;
            out_next.net_id      = rec.net_id;
            out_next.dev_id      = rec.dev_id;
            out_next.message     = rec.message;
            out_next.status      = rec.status;
            out_next.publish     = 1'b0;
            out_next.repeat_count = dup_reg;

            if (rec_valid && (rec.status == ST_OK))
            begin
                last_time_next = rec.now_ms;
                if (same)
                begin
                    if (dup_reg != COUNT_MAX)
                    begin
                        dup_next         = dup_inc;
                        out_next.publish = (dup_inc == min_repeats_reg);
                    end
                end
                else
                begin
                    last_net_next    = rec.net_id;
                    last_dev_next    = rec.dev_id;
                    last_msg_next    = rec.message;
                    dup_next         = 8'd1;
                    out_next.publish = (min_repeats_reg == 8'd1);
                end
                out_next.repeat_count = dup_next;
            end
        end
    end

    // Filter state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_net_reg  <= '0;
            last_dev_reg  <= '0;
            last_msg_reg  <= '0;
            last_time_reg <= '0;
            dup_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_net_reg  <= last_net_next;
            last_dev_reg  <= last_dev_next;
            last_msg_reg  <= last_msg_next;
            last_time_reg <= last_time_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Publish only on a good frame
    a_publish_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.publish) |-> (out_data.status == ST_OK))
        else $error("publish on a failed frame");

    // Publish means the count just reached the threshold
    a_publish_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.publish) |-> (out_data.repeat_count == min_repeats_reg))
        else $error("publish with count off threshold");

    // A good frame always leaves a nonzero count
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_OK)) |-> (out_data.repeat_count != 8'd0))
        else $error("good frame with zero count");

    // Input stalls only while a checked frame is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (rec_valid && out_valid_reg && out_stall))
        else $error("input stalled without a pending frame");

endmodule

`default_nettype wire

[rtl/afcd_frame.sv]
`default_nettype none

module afcd_frame (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire afcd_pkg::in_t       in_data,
    output logic                     rec_valid,
    input  wire logic                rec_take,
    output afcd_pkg::frame_rec_t     rec
);
    import afcd_pkg::*;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]       crc_reg, crc_next;
    logic [31:0]      net_reg, net_next;
    logic [7:0]       msg_reg, msg_next;
    logic [1:0]       fail_reg, fail_next;
    logic [31:0]      dev_reg, dev_next;
    logic             rec_valid_reg, rec_valid_next;
    frame_rec_t       rec_reg, rec_next;

    logic             accept;
    logic [IDX_W-1:0] idx;
    logic [7:0]       crc_base;
    logic             last_byte;
    logic [7:0]       b;

    // A pending record blocks only until the filter takes it
    assign in_stall = rec_valid_reg && !rec_take;
    assign accept   = in_valid && !in_stall;
    assign b        = in_data.rx_byte;

    // Position of this byte; a start mark or an out-of-range count restarts
    always_comb
    begin
        if (in_data.start_of_frame || (byte_index_reg >= IDX_W'(FRAME_BYTES)))
            idx = '0;
        else
            idx = byte_index_reg;
        crc_base  = (idx == '0) ? 8'h00 : crc_reg;
        last_byte = (idx == IDX_W'(FRAME_BYTES - 1));
    end

    // Field assembly and checks
    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        net_next        = net_reg;
        msg_next        = msg_reg;
        fail_next       = fail_reg;
        dev_next        = dev_reg;
        rec_valid_next  = rec_valid_reg;
        rec_next        = rec_reg;

        if (rec_take)
            rec_valid_next = 1'b0;

        if (accept)
        begin
            if (idx <= IDX_W'(NET_LAST_IDX))
                net_next = (idx == '0) ? {24'h0, b} : {net_reg[23:0], b};
            else if (idx == IDX_W'(MSG_IDX))
                msg_next = b;
            else if (idx == IDX_W'(COMPL_IDX))
                fail_next = {1'b0, ((msg_reg ^ b) != 8'hFF)};
            else if (idx == IDX_W'(CRC_IDX))
                fail_next[FAIL_CRC] = fail_reg[FAIL_CRC] | (b != crc_reg);
            else
                dev_next = (idx == IDX_W'(DEV_FIRST_IDX)) ? {24'h0, b} : {dev_reg[23:0], b};

            if (idx < IDX_W'(CRC_IDX))
                crc_next = crc8_step(crc_base, b);
            else
                crc_next = crc_base;

            if (last_byte)
            begin
                byte_index_next = '0;
                rec_valid_next  = 1'b1;
                rec_next.net_id  = net_reg;
                rec_next.dev_id  = {dev_reg[23:0], b};
                rec_next.message = msg_reg;
                rec_next.now_ms  = in_data.now_ms;
                if (fail_reg[FAIL_COMPL])
                    rec_next.status = ST_COMPL_ERR;
                else if (fail_reg[FAIL_CRC])
                    rec_next.status = ST_CRC_ERR;
                else
                    rec_next.status = ST_OK;
            end
            else
                byte_index_next = idx + IDX_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            crc_reg        <= '0;
            rec_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            rec_valid_reg  <= rec_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        net_reg  <= net_next;
        msg_reg  <= msg_next;
        fail_reg <= fail_next;
        dev_reg  <= dev_next;
        rec_reg  <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

`default_nettype wire
